### hw/rtl/rcpd_pkg.sv
// Shared types and constants for the RC PWM/PPM pulse decoder.
`default_nettype none

package rcpd_pkg;

  localparam int unsigned TimeW    = 16;
  localparam int unsigned ChanW    = 4;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [1:0] {
    ModePwm       = 2'd0,
    ModePpmPeriod = 2'd1,
    ModePpmEdge   = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDecodeMode   = 3'd0,
    CfgPolarity     = 3'd1,
    CfgScale        = 3'd2,
    CfgSyncMin      = 3'd3,
    CfgFrameChans   = 3'd4,
    CfgFailsafeChan = 3'd5,
    CfgFailsafeLow  = 3'd6,
    CfgFailsafeHigh = 3'd7
  } cfg_idx_e;

endpackage

`default_nettype wire

### hw/rtl/rc_pwm_ppm_pulse_decoder_top.sv
// RC receiver pulse decoder: per-channel PWM and PPM frame decoding with failsafe counters.
// One edge request enters an input register, is decoded by a single pass of logic (wrapped
// timer difference, one 16x16 multiply, window compares) and lands in a result register.
// An edge can be accepted every cycle; the only thing that holds the input side is a stalled
// result sitting in the result register while the next edge already waits in the input
// register. Decoder state (rise times, PPM slot, failsafe counters) is updated as an edge
// moves into the result stage, so back-to-back edges see each other's effect. Configuration
// is written through a plain indexed write port; the user must write it only while the
// block is idle, and the block itself does not enforce this.
`default_nettype none

module rc_pwm_ppm_pulse_decoder_top #(
  parameter int unsigned NUM_CHANNELS = 8,
  parameter int unsigned SCALE_SHIFT  = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rcpd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rcpd_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [rcpd_pkg::TimeW-1:0]    capture_time_i,
  input  wire logic                          pin_level_i,
  input  wire logic [rcpd_pkg::ChanW-1:0]    source_channel_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [rcpd_pkg::ChanW-1:0]    channel_o,
  output      logic [rcpd_pkg::TimeW-1:0]    width_o,
  output      logic [rcpd_pkg::TimeW-1:0]    good_count_o,
  output      logic [rcpd_pkg::TimeW-1:0]    noise_count_o
);
  import rcpd_pkg::*;

  localparam int unsigned IdxW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned ProdW = 2 * TimeW;

  // configuration
  logic [1:0]       mode_q;
  logic             polarity_q;
  logic [TimeW-1:0] scale_q;
  logic [TimeW-1:0] sync_min_q;
  logic [SlotW-1:0] frame_chans_q;
  logic [ChanW-1:0] fs_chan_q;
  logic [TimeW-1:0] fs_low_q;
  logic [TimeW-1:0] fs_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= ModePwm;
      polarity_q    <= 1'b1;
      scale_q       <= 16'hFFFF;
      sync_min_q    <= 16'd7000;
      frame_chans_q <= 5'd8;
      fs_chan_q     <= 4'd1;
      fs_low_q      <= '0;
      fs_high_q     <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDecodeMode:   mode_q        <= cfg_data_i[1:0];
        CfgPolarity:     polarity_q    <= cfg_data_i[0];
        CfgScale:        scale_q       <= cfg_data_i;
        CfgSyncMin:      sync_min_q    <= cfg_data_i;
        CfgFrameChans:   frame_chans_q <= cfg_data_i[SlotW-1:0];
        CfgFailsafeChan: fs_chan_q     <= cfg_data_i[ChanW-1:0];
        CfgFailsafeLow:  fs_low_q      <= cfg_data_i;
        CfgFailsafeHigh: fs_high_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic             in_valid_q;
  logic [TimeW-1:0] time_q;
  logic             pin_q;
  logic [ChanW-1:0] src_q;
  logic             out_free;
  logic             advance;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      time_q <= capture_time_i;
      pin_q  <= pin_level_i;
      src_q  <= source_channel_i;
    end
  end

  // decoder state
  logic [TimeW-1:0] rise_q [NUM_CHANNELS];
  logic [TimeW-1:0] last_edge_q;
  logic [SlotW-1:0] slot_q;
  logic [TimeW-1:0] good_q;
  logic [TimeW-1:0] bad_q;

  logic             active;
  logic             src_ok;
  logic [IdxW-1:0]  src_idx;
  logic [TimeW-1:0] ppm_pulse;
  logic             ppm_in_frame;
  logic             ppm_emit_ok;
  logic             rise_we;
  logic             last_we;
  logic [SlotW-1:0] slot_d;
  logic             res_valid;
  logic [TimeW-1:0] raw;
  logic [SlotW-1:0] chan_full;
  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] prod_sh;
  logic [TimeW-1:0] scaled;
  logic             is_fs;
  logic             in_window;
  logic [TimeW-1:0] good_d;
  logic [TimeW-1:0] bad_d;

  assign active       = (pin_q == polarity_q);
  assign src_ok       = (src_q != '0) && ({1'b0, src_q} <= SlotW'(NUM_CHANNELS));
  assign src_idx      = IdxW'(src_q - 4'd1);
  assign ppm_pulse    = time_q - last_edge_q;
  assign ppm_in_frame = (slot_q != '0) && (slot_q <= frame_chans_q);
  assign ppm_emit_ok  = ppm_in_frame && (slot_q <= SlotW'(NUM_CHANNELS));

  always_comb begin
    rise_we   = 1'b0;
    last_we   = 1'b0;
    slot_d    = slot_q;
    res_valid = 1'b0;
    raw       = ppm_pulse;
    chan_full = slot_q;
    case (mode_q)
      ModePwm: begin
        raw       = time_q - rise_q[src_idx];
        chan_full = {1'b0, src_q};
        if (src_ok) begin
          rise_we   = active;
          res_valid = !active;
        end
      end
      ModePpmPeriod: begin
        if (active) begin
          last_we = 1'b1;
          if (ppm_pulse > sync_min_q) begin
            slot_d = SlotW'(1);
          end else if (ppm_in_frame) begin
            res_valid = ppm_emit_ok;
            slot_d    = slot_q + 5'd1;
          end
        end
      end
      ModePpmEdge: begin
        last_we = 1'b1;
        if (active) begin
          if (ppm_pulse > sync_min_q) begin
            slot_d = SlotW'(1);
          end
        end else if (ppm_in_frame) begin
          res_valid = ppm_emit_ok;
          slot_d    = slot_q + 5'd1;
        end
      end
      default: ;
    endcase
  end

  // scale: ((raw * scale) << shift) >> 16 in 32 bits
  assign prod      = ProdW'(raw) * ProdW'(scale_q);
  assign prod_sh   = prod << SCALE_SHIFT;
  assign scaled    = prod_sh[ProdW-1:TimeW];
  assign is_fs     = res_valid && (chan_full == {1'b0, fs_chan_q});
  assign in_window = (scaled > fs_low_q) && (scaled < fs_high_q);
  assign good_d    = (is_fs && in_window)  ? good_q + 16'd1 : good_q;
  assign bad_d     = (is_fs && !in_window) ? bad_q + 16'd1  : bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rise_q[i] <= '0;
      end
      last_edge_q <= '0;
      slot_q      <= '0;
      good_q      <= '0;
      bad_q       <= '0;
    end else if (advance) begin
      if (rise_we) begin
        rise_q[src_idx] <= time_q;
      end
      if (last_we) begin
        last_edge_q <= time_q;
      end
      slot_q <= slot_d;
      good_q <= good_d;
      bad_q  <= bad_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid && out_free) begin
      channel_o     <= chan_full[ChanW-1:0];
      width_o       <= scaled;
      good_count_o  <= good_d;
      noise_count_o <= bad_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rcpd_checker.sv
// Port-level assertions for the RC pulse decoder, bound to the top level.
`default_nettype none

module rcpd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [rcpd_pkg::ChanW-1:0]    channel_o,
  input wire logic [rcpd_pkg::TimeW-1:0]    width_o,
  input wire logic [rcpd_pkg::TimeW-1:0]    good_count_o,
  input wire logic [rcpd_pkg::TimeW-1:0]    noise_count_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(channel_o) && $stable(width_o)
      && $stable(good_count_o) && $stable(noise_count_o))
    else $error("stalled result changed");

  // the input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // back-to-back results: at most one counter advances, by one
  a_good_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i ##1 out_valid_o |->
      good_count_o == $past(good_count_o) || good_count_o == $past(good_count_o) + 16'd1)
    else $error("good counter jumped");

  a_noise_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i ##1 out_valid_o |->
      noise_count_o == $past(noise_count_o) || noise_count_o == $past(noise_count_o) + 16'd1)
    else $error("noise counter jumped");

  a_one_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i ##1 out_valid_o |->
      good_count_o == $past(good_count_o) || noise_count_o == $past(noise_count_o))
    else $error("both counters advanced on one result");

endmodule

bind rc_pwm_ppm_pulse_decoder_top rcpd_checker u_rcpd_checker (.*);

`default_nettype wire
